// ===== rtl/mdf_pkg.sv =====
`default_nettype none
package mdf_pkg;

  // Frame layout
  localparam int unsigned INFO_LEN  = 28;
  localparam int unsigned MSG_LEN   = 136;
  localparam int unsigned AUDIO_MAX = 200;

  localparam int unsigned LEN_W = 24;
  localparam int unsigned CNT_W = 8;

  localparam logic [CNT_W-1:0] INFO_LAST  = CNT_W'(INFO_LEN - 1);
  localparam logic [CNT_W-1:0] MSG_LAST   = CNT_W'(MSG_LEN - 1);
  localparam logic [LEN_W-1:0] AUDIO_LIM  = LEN_W'(AUDIO_MAX);

  // Configuration register indexes
  localparam logic [2:0] REG_SYNC_FIRST   = 3'd0;
  localparam logic [2:0] REG_SYNC_SECOND  = 3'd1;
  localparam logic [2:0] REG_CODE_AVC     = 3'd2;
  localparam logic [2:0] REG_CODE_HEVC    = 3'd3;
  localparam logic [2:0] REG_CODE_RAW_RGB = 3'd4;
  localparam logic [2:0] REG_CODE_ALAW    = 3'd5;
  localparam logic [2:0] REG_CODE_MESSAGE = 3'd6;
  localparam logic [2:0] REG_VIDEO_LIMIT  = 3'd7;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // Media kinds
  localparam logic [2:0] KIND_AVC  = 3'd0;
  localparam logic [2:0] KIND_HEVC = 3'd1;
  localparam logic [2:0] KIND_RGB  = 3'd2;
  localparam logic [2:0] KIND_ALAW = 3'd3;
  localparam logic [2:0] KIND_MSG  = 3'd4;

  // Result kinds
  localparam logic [1:0] RK_PAYLOAD = 2'd0;
  localparam logic [1:0] RK_EMPTY   = 2'd1;
  localparam logic [1:0] RK_LEN_ERR = 2'd2;

  typedef struct packed {
    logic [7:0]       sync_first;
    logic [7:0]       sync_second;
    logic [7:0]       code_avc;
    logic [7:0]       code_hevc;
    logic [7:0]       code_raw_rgb;
    logic [7:0]       code_alaw;
    logic [7:0]       code_message;
    logic [LEN_W-1:0] video_len_limit;
  } mdf_cfg_t;

endpackage
`default_nettype wire

// ===== rtl/mdf_if.sv =====
`default_nettype none
// Input byte channel
interface mdf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// Result channel
interface mdf_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [1:0]  media_kind;
  logic [7:0]  payload_byte;
  logic [31:0] frame_width;
  logic [31:0] frame_height;
  logic        last_byte;

  modport source (
    output valid, output result_kind, output media_kind, output payload_byte,
    output frame_width, output frame_height, output last_byte, input ready
  );
  modport sink (
    input valid, input result_kind, input media_kind, input payload_byte,
    input frame_width, input frame_height, input last_byte, output ready
  );
endinterface
`default_nettype wire

// ===== rtl/mdf_cfg_regs.sv =====
`default_nettype none
module mdf_cfg_regs
  import mdf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output mdf_cfg_t                   cfg
);

  mdf_cfg_t cfg_r;

  // Write one register per enabled cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_first      <= 8'd0;
      cfg_r.sync_second     <= 8'd0;
      cfg_r.code_avc        <= 8'd0;
      cfg_r.code_hevc       <= 8'd1;
      cfg_r.code_raw_rgb    <= 8'd2;
      cfg_r.code_alaw       <= 8'd3;
      cfg_r.code_message    <= 8'd4;
      cfg_r.video_len_limit <= LEN_W'(3584000);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SYNC_FIRST:   cfg_r.sync_first      <= cfg_wdata[7:0];
        REG_SYNC_SECOND:  cfg_r.sync_second     <= cfg_wdata[7:0];
        REG_CODE_AVC:     cfg_r.code_avc        <= cfg_wdata[7:0];
        REG_CODE_HEVC:    cfg_r.code_hevc       <= cfg_wdata[7:0];
        REG_CODE_RAW_RGB: cfg_r.code_raw_rgb    <= cfg_wdata[7:0];
        REG_CODE_ALAW:    cfg_r.code_alaw       <= cfg_wdata[7:0];
        REG_CODE_MESSAGE: cfg_r.code_message    <= cfg_wdata[7:0];
        REG_VIDEO_LIMIT:  cfg_r.video_len_limit <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// ===== rtl/mdf_parse_core.sv =====
`default_nettype none
module mdf_parse_core
  import mdf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  mdf_cfg_t        cfg,
  input  wire logic       item_valid,
  input  wire logic [7:0] item_byte,
  output logic            item_take,
  mdf_out_if.source       out_ch
);

  localparam logic [2:0] PH_HUNT    = 3'd0;
  localparam logic [2:0] PH_TSKIP   = 3'd1;
  localparam logic [2:0] PH_TYPE    = 3'd2;
  localparam logic [2:0] PH_HEADER  = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_MSG     = 3'd5;

  logic [2:0]       phase_r, phase_nxt;
  logic             prev_sync_r, prev_sync_nxt;
  logic [2:0]       kind_r, kind_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]      width_r, width_nxt;
  logic [31:0]      height_r, height_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] rem_r, rem_nxt;

  logic             emit;
  logic [1:0]       emit_rk;
  logic             emit_last;

  logic             out_valid_r;
  logic [1:0]       out_rk_r;
  logic [1:0]       out_mk_r;
  logic [7:0]       out_byte_r;
  logic [31:0]      out_width_r;
  logic [31:0]      out_height_r;
  logic             out_last_r;

  // Take the held item when the result register has room
  assign item_take = item_valid && (!out_valid_r || out_ch.ready);

  // Next state and result for the held byte
  always_comb begin
    logic [LEN_W-1:0] lim;
    logic             len_bad;
    phase_nxt     = phase_r;
    prev_sync_nxt = prev_sync_r;
    kind_nxt      = kind_r;
    cnt_nxt       = cnt_r;
    width_nxt     = width_r;
    height_nxt    = height_r;
    len_nxt       = len_r;
    rem_nxt       = rem_r;
    emit          = 1'b0;
    emit_rk       = RK_PAYLOAD;
    emit_last     = 1'b0;
    lim           = (kind_r == KIND_ALAW) ? AUDIO_LIM : cfg.video_len_limit;
    // top length byte arrives with the last header byte
    len_bad       = (item_byte != 8'd0) || (len_r > lim);

    case (phase_r)
      PH_TSKIP: begin
        phase_nxt = PH_TYPE;
      end
      PH_TYPE: begin
        phase_nxt  = PH_HEADER;
        cnt_nxt    = '0;
        width_nxt  = '0;
        height_nxt = '0;
        len_nxt    = '0;
        if (item_byte == cfg.code_avc) begin
          kind_nxt = KIND_AVC;
        end else if (item_byte == cfg.code_hevc) begin
          kind_nxt = KIND_HEVC;
        end else if (item_byte == cfg.code_raw_rgb) begin
          kind_nxt = KIND_RGB;
        end else if (item_byte == cfg.code_alaw) begin
          kind_nxt = KIND_ALAW;
        end else if (item_byte == cfg.code_message) begin
          kind_nxt  = KIND_MSG;
          phase_nxt = PH_MSG;
        end else begin
          // unknown type: back to hunt, header state untouched
          phase_nxt     = PH_HUNT;
          prev_sync_nxt = 1'b0;
          cnt_nxt       = cnt_r;
          width_nxt     = width_r;
          height_nxt    = height_r;
          len_nxt       = len_r;
        end
      end
      PH_MSG: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r >= MSG_LAST) begin
          phase_nxt     = PH_HUNT;
          prev_sync_nxt = 1'b0;
        end
      end
      PH_HEADER: begin
        cnt_nxt = cnt_r + 1'b1;
        // little-endian words: width at 4, height at 8, length at 24
        if (cnt_r >= 8'd4 && cnt_r < 8'd8) begin
          width_nxt[8*cnt_r[1:0] +: 8] = item_byte;
        end else if (cnt_r >= 8'd8 && cnt_r < 8'd12) begin
          height_nxt[8*cnt_r[1:0] +: 8] = item_byte;
        end else if (cnt_r >= CNT_W'(INFO_LEN - 4) && cnt_r < INFO_LAST) begin
          len_nxt[8*cnt_r[1:0] +: 8] = item_byte;
        end
        if (cnt_r == INFO_LAST) begin
          if (len_bad) begin
            emit          = 1'b1;
            emit_rk       = RK_LEN_ERR;
            emit_last     = 1'b1;
            phase_nxt     = PH_HUNT;
            prev_sync_nxt = 1'b0;
          end else if (len_r == '0) begin
            emit          = 1'b1;
            emit_rk       = RK_EMPTY;
            emit_last     = 1'b1;
            phase_nxt     = PH_HUNT;
            prev_sync_nxt = 1'b0;
          end else begin
            rem_nxt   = len_r;
            phase_nxt = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        emit    = 1'b1;
        emit_rk = RK_PAYLOAD;
        rem_nxt = rem_r - 1'b1;
        if (rem_r == LEN_W'(1)) begin
          emit_last     = 1'b1;
          phase_nxt     = PH_HUNT;
          prev_sync_nxt = 1'b0;
        end
      end
      default: begin
        // hunt over a two-byte sliding window
        if (prev_sync_r && item_byte == cfg.sync_second) begin
          prev_sync_nxt = 1'b0;
          phase_nxt     = PH_TSKIP;
        end else begin
          phase_nxt     = PH_HUNT;
          prev_sync_nxt = (item_byte == cfg.sync_first);
        end
      end
    endcase
  end

  // Advance parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      prev_sync_r <= 1'b0;
      kind_r      <= KIND_AVC;
      cnt_r       <= '0;
      width_r     <= '0;
      height_r    <= '0;
      len_r       <= '0;
      rem_r       <= '0;
    end else if (item_take) begin
      phase_r     <= phase_nxt;
      prev_sync_r <= prev_sync_nxt;
      kind_r      <= kind_nxt;
      cnt_r       <= cnt_nxt;
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      len_r       <= len_nxt;
      rem_r       <= rem_nxt;
    end
  end

  // Result register: load on emit, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (item_take && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take && emit) begin
      out_rk_r     <= emit_rk;
      out_mk_r     <= kind_r[1:0];
      out_byte_r   <= (emit_rk == RK_PAYLOAD) ? item_byte : 8'd0;
      out_width_r  <= (kind_r == KIND_ALAW) ? 32'd0 : width_r;
      out_height_r <= (kind_r == KIND_ALAW) ? 32'd0 : height_r;
      out_last_r   <= emit_last;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_kind  = out_rk_r;
  assign out_ch.media_kind   = out_mk_r;
  assign out_ch.payload_byte = out_byte_r;
  assign out_ch.frame_width  = out_width_r;
  assign out_ch.frame_height = out_height_r;
  assign out_ch.last_byte    = out_last_r;

endmodule
`default_nettype wire

// ===== rtl/media_stream_deframer_unit.sv =====
`default_nettype none
// Path: an accepted byte is held in the input register; when the core takes it,
// any result it gives is loaded into the result register and shown as valid.
// Throughput: one byte per cycle; a byte waits in the input register only
// while the result register holds a result that has not been taken.
// Reset: synchronous active-low rst_n clears the hunt state, both valid
// flags and all configuration registers to their defaults.
module media_stream_deframer_unit
  import mdf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  mdf_in_if.sink                     in_if,
  mdf_out_if.source                  out_if,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  mdf_cfg_t   cfg;
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       core_take;

  mdf_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Input register: refill as the core takes the held item
  assign in_if.ready = !s1_valid_r || core_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.valid && in_if.ready) begin
      s1_valid_r <= 1'b1;
    end else if (core_take) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      s1_byte_r <= in_if.rx_byte;
    end
  end

  mdf_parse_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (s1_valid_r),
    .item_byte  (s1_byte_r),
    .item_take  (core_take),
    .out_ch     (out_if)
  );

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
module tb_top;
  import mdf_pkg::*;

  localparam int unsigned ITEM_TARGET  = 1450;
  localparam int unsigned PHASE_BYTES  = 260;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned CYCLE_LIMIT  = 500000;

  typedef enum logic [2:0] {
    ST_HUNT, ST_SKIP, ST_TYPE, ST_HDR, ST_BODY, ST_MSG
  } parse_state_t;

  typedef struct packed {
    logic [1:0]  rkind;
    logic [1:0]  mkind;
    logic [7:0]  data;
    logic [31:0] fwidth;
    logic [31:0] fheight;
    logic        is_last;
  } deframe_result_t;

  // Mirror of the deframer: parses accepted bytes, holds the results they owe
  class deframe_checker;
    mdf_cfg_t        cfg;
    parse_state_t    st;
    bit              armed;
    logic [2:0]      kind;
    logic [7:0]      hdr_cnt;
    logic [31:0]     wd, ht, len, left;
    deframe_result_t results_due[$];
    int unsigned     fails;

    function new();
      cfg.sync_first      = 8'd0;
      cfg.sync_second     = 8'd0;
      cfg.code_avc        = 8'd0;
      cfg.code_hevc       = 8'd1;
      cfg.code_raw_rgb    = 8'd2;
      cfg.code_alaw       = 8'd3;
      cfg.code_message    = 8'd4;
      cfg.video_len_limit = 24'd3584000;
      st      = ST_HUNT;
      armed   = 1'b0;
      kind    = KIND_AVC;
      hdr_cnt = '0;
      wd      = '0;
      ht      = '0;
      len     = '0;
      left    = '0;
      fails   = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_SYNC_FIRST:   cfg.sync_first      = val[7:0];
        REG_SYNC_SECOND:  cfg.sync_second     = val[7:0];
        REG_CODE_AVC:     cfg.code_avc        = val[7:0];
        REG_CODE_HEVC:    cfg.code_hevc       = val[7:0];
        REG_CODE_RAW_RGB: cfg.code_raw_rgb    = val[7:0];
        REG_CODE_ALAW:    cfg.code_alaw       = val[7:0];
        REG_CODE_MESSAGE: cfg.code_message    = val[7:0];
        REG_VIDEO_LIMIT:  cfg.video_len_limit = val;
        default: ;
      endcase
    endfunction

    function void rehunt();
      st    = ST_HUNT;
      armed = 1'b0;
    endfunction

    // Audio results carry no picture size
    function void owe(logic [1:0] rk, logic [7:0] pb, logic lst);
      deframe_result_t r;
      r.rkind   = rk;
      r.mkind   = kind[1:0];
      r.data    = pb;
      r.fwidth  = (kind == KIND_ALAW) ? 32'd0 : wd;
      r.fheight = (kind == KIND_ALAW) ? 32'd0 : ht;
      r.is_last = lst;
      results_due.push_back(r);
    endfunction

    function void take_byte(logic [7:0] b);
      logic [31:0] cap;
      int unsigned i;
      bit          hit;
      case (st)
        ST_SKIP: st = ST_TYPE;
        ST_TYPE: begin
          // Lowest code register wins on collisions
          hit = 1'b1;
          if (b == cfg.code_avc) kind = KIND_AVC;
          else if (b == cfg.code_hevc) kind = KIND_HEVC;
          else if (b == cfg.code_raw_rgb) kind = KIND_RGB;
          else if (b == cfg.code_alaw) kind = KIND_ALAW;
          else if (b == cfg.code_message) kind = KIND_MSG;
          else hit = 1'b0;
          if (!hit) begin
            rehunt();
          end else begin
            hdr_cnt = '0;
            wd      = '0;
            ht      = '0;
            len     = '0;
            st      = (kind == KIND_MSG) ? ST_MSG : ST_HDR;
          end
        end
        ST_MSG: begin
          hdr_cnt = hdr_cnt + 8'd1;
          if (hdr_cnt >= CNT_W'(MSG_LEN)) rehunt();
        end
        ST_HDR: begin
          i = hdr_cnt;
          if (i >= 4 && i < 8) wd[8*(i-4) +: 8] = b;
          else if (i >= 8 && i < 12) ht[8*(i-8) +: 8] = b;
          else if (i >= INFO_LEN - 4 && i < INFO_LEN) len[8*(i-(INFO_LEN-4)) +: 8] = b;
          hdr_cnt = hdr_cnt + 8'd1;
          if (hdr_cnt >= CNT_W'(INFO_LEN)) begin
            cap = (kind == KIND_ALAW) ? 32'(AUDIO_MAX) : 32'(cfg.video_len_limit);
            if (len[31] || len > cap) begin
              owe(RK_LEN_ERR, 8'd0, 1'b1);
              rehunt();
            end else if (len == 0) begin
              owe(RK_EMPTY, 8'd0, 1'b1);
              rehunt();
            end else begin
              left = len;
              st   = ST_BODY;
            end
          end
        end
        ST_BODY: begin
          if (left != 0) left = left - 1;
          if (left == 0) begin
            owe(RK_PAYLOAD, b, 1'b1);
            rehunt();
          end else begin
            owe(RK_PAYLOAD, b, 1'b0);
          end
        end
        default: begin
          if (armed && b == cfg.sync_second) begin
            armed = 1'b0;
            st    = ST_SKIP;
          end else begin
            st    = ST_HUNT;
            armed = (b == cfg.sync_first);
          end
        end
      endcase
    endfunction

    function void cmp(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %0h, got %0h", name, want, got);
        fails++;
      end
    endfunction

    function void check_result(deframe_result_t got);
      deframe_result_t want;
      if (results_due.size() == 0) begin
        $error("result item with nothing due: kind %0h byte %0h", got.rkind, got.data);
        fails++;
      end else begin
        want = results_due.pop_front();
        cmp("result_kind", want.rkind, got.rkind);
        cmp("media_kind", want.mkind, got.mkind);
        cmp("payload_byte", want.data, got.data);
        cmp("frame_width", want.fwidth, got.fwidth);
        cmp("frame_height", want.fheight, got.fheight);
        cmp("last_byte", want.is_last, got.is_last);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  mdf_in_if  in_ch ();
  mdf_out_if out_ch ();

  deframe_checker sb;
  bit             idle_on;
  bit             rx_hold;
  int unsigned    bytes_sent;
  int unsigned    cycles;

  media_stream_deframer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Bound the run
  initial cycles = 0;
  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Sample both channels; inputs first so a same-edge result finds its prediction
  always @(posedge clk) begin : channel_monitor
    deframe_result_t got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) sb.take_byte(in_ch.rx_byte);
      if (out_ch.valid && out_ch.ready) begin
        got.rkind   = out_ch.result_kind;
        got.mkind   = out_ch.media_kind;
        got.data    = out_ch.payload_byte;
        got.fwidth  = out_ch.frame_width;
        got.fheight = out_ch.frame_height;
        got.is_last = out_ch.last_byte;
        sb.check_result(got);
      end
    end
  end

  // Result side: random stalls per item, one long hold-off on request
  initial begin : result_sink
    int unsigned gap;
    wait (rst_n === 1'b1);
    forever begin
      if (rx_hold) begin
        gap     = HOLD_CYCLES;
        rx_hold = 1'b0;
      end else begin
        gap = idle_on ? $urandom_range(0, 13) : 0;
      end
      if (gap != 0) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 13) : 0;
    if (gap != 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_noise(input int unsigned n);
    repeat (n) send_byte(8'($urandom));
  endtask

  task automatic send_lead(input logic [7:0] code);
    send_byte(sb.cfg.sync_first);
    send_byte(sb.cfg.sync_second);
    send_byte(8'($urandom));
    send_byte(code);
  endtask

  // Little-endian words at their header offsets, filler elsewhere
  task automatic send_header(input logic [31:0] w, input logic [31:0] h,
                             input logic [31:0] n);
    logic [7:0] b;
    for (int i = 0; i < INFO_LEN; i++) begin
      if (i >= 4 && i < 8) b = w[8*(i-4) +: 8];
      else if (i >= 8 && i < 12) b = h[8*(i-8) +: 8];
      else if (i >= INFO_LEN - 4) b = n[8*(i-(INFO_LEN-4)) +: 8];
      else b = 8'($urandom);
      send_byte(b);
    end
  endtask

  task automatic fixed_frame(input logic [7:0] code, input logic [31:0] w,
                             input logic [31:0] h, input logic [31:0] n,
                             input int unsigned body);
    send_lead(code);
    send_header(w, h, n);
    send_noise(body);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 3))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic bit is_known(logic [7:0] c);
    return c == sb.cfg.code_avc || c == sb.cfg.code_hevc || c == sb.cfg.code_raw_rgb ||
           c == sb.cfg.code_alaw || c == sb.cfg.code_message;
  endfunction

  // Length ceiling that the block will apply to this type byte
  function automatic logic [31:0] len_cap(logic [7:0] c);
    if (c == sb.cfg.code_avc || c == sb.cfg.code_hevc || c == sb.cfg.code_raw_rgb)
      return 32'(sb.cfg.video_len_limit);
    return 32'(AUDIO_MAX);
  endfunction

  function automatic logic [31:0] pick_len(logic [31:0] cap);
    logic [31:0] n;
    case ($urandom_range(0, 9))
      0: n = 32'd0;
      1: n = cap + 32'd1 + $urandom_range(0, 300);
      2: n = {1'b1, 31'($urandom)};
      3: begin
        n = $urandom;
        if (!n[31] && n <= cap) n = cap + 32'd1;
      end
      4: n = (cap <= 200) ? cap : $urandom_range(1, 24);
      default: n = (cap == 0) ? 32'd0 : $urandom_range(1, (cap < 24) ? cap : 24);
    endcase
    return n;
  endfunction

  task automatic media_frame(input logic [7:0] code, input bit cut);
    logic [31:0] cap;
    logic [31:0] n;
    int unsigned body;
    cap  = len_cap(code);
    n    = pick_len(cap);
    body = (!n[31] && n != 0 && n <= cap) ? n : 0;
    if (cut && body > 0) body = $urandom_range(0, body - 1);
    fixed_frame(code, rand_word(), rand_word(), n, body);
  endtask

  // Mostly well-formed frames; some truncated, some with unknown type
  task automatic random_frame();
    logic [7:0]  code;
    int unsigned pick;
    bit          cut;
    send_noise($urandom_range(0, 2));
    pick = $urandom_range(0, 9);
    cut  = ($urandom_range(0, 11) == 0) && (sb.cfg.video_len_limit <= 24'd4096);
    case (pick)
      0, 1: code = sb.cfg.code_avc;
      2, 3: code = sb.cfg.code_hevc;
      4, 5: code = sb.cfg.code_raw_rgb;
      6, 7: code = sb.cfg.code_alaw;
      8: code = sb.cfg.code_message;
      default: begin
        code = 8'($urandom);
        while (is_known(code)) code = 8'($urandom);
      end
    endcase
    if (pick == 8) begin
      send_lead(code);
      send_noise(cut ? $urandom_range(0, MSG_LEN - 1) : MSG_LEN);
    end else if (pick == 9) begin
      send_lead(code);
    end else begin
      media_frame(code, cut);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic set_regs(input logic [7:0] sf, input logic [7:0] ss,
                          input logic [7:0] avc, input logic [7:0] hevc,
                          input logic [7:0] rgb, input logic [7:0] alaw,
                          input logic [7:0] msg, input logic [23:0] lim);
    write_reg(REG_SYNC_FIRST, CFG_DATA_W'(sf));
    write_reg(REG_SYNC_SECOND, CFG_DATA_W'(ss));
    write_reg(REG_CODE_AVC, CFG_DATA_W'(avc));
    write_reg(REG_CODE_HEVC, CFG_DATA_W'(hevc));
    write_reg(REG_CODE_RAW_RGB, CFG_DATA_W'(rgb));
    write_reg(REG_CODE_ALAW, CFG_DATA_W'(alaw));
    write_reg(REG_CODE_MESSAGE, CFG_DATA_W'(msg));
    write_reg(REG_VIDEO_LIMIT, lim);
  endtask

  // Drop valid, wait for every owed result, then let the pipeline empty
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned phase_start;
    sb            = new();
    idle_on       = 1'b1;
    rx_hold       = 1'b0;
    bytes_sent    = 0;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = 8'd0;
    out_ch.ready  = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed frames under reset settings
    send_byte(8'h5C);
    fixed_frame(sb.cfg.code_avc, 32'hFFFF_FFFF, 32'h0, 32'd1, 1);
    fixed_frame(sb.cfg.code_hevc, 32'h0, 32'hFFFF_FFFF, 32'd0, 0);
    fixed_frame(sb.cfg.code_raw_rgb, 32'h1234_5678, 32'h9ABC_DEF0,
                32'(sb.cfg.video_len_limit) + 32'd1, 0);
    fixed_frame(sb.cfg.code_raw_rgb, 32'h1, 32'h2, 32'h8000_0000, 0);
    fixed_frame(sb.cfg.code_alaw, 32'h5, 32'h6, 32'd0, 0);
    fixed_frame(sb.cfg.code_alaw, 32'h7, 32'h8, 32'hFFFF_FFFF, 0);
    fixed_frame(sb.cfg.code_alaw, 32'h9, 32'hA, 32'(AUDIO_MAX) + 32'd1, 0);
    fixed_frame(sb.cfg.code_alaw, 32'hB, 32'hC, 32'd3, 3);
    send_lead(sb.cfg.code_message);
    send_noise(MSG_LEN);
    send_lead(8'h77);
    fixed_frame(sb.cfg.code_avc, 32'hD, 32'hE, 32'd2, 2);
    settle();

    for (int p = 0; bytes_sent < ITEM_TARGET; p++) begin
      case (p)
        0: set_regs(8'hA5, 8'h5A, 8'h10, 8'h20, 8'h30, 8'h40, 8'h50, 24'd24);
        // Every code equal: the first code register must win
        1: set_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 24'd0);
        2: set_regs(8'h00, 8'hFF, 8'hFE, 8'h80, 8'h7F, 8'h01, 8'h00, 24'hFF_FFFF);
        default: set_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                          8'($urandom), 8'($urandom), 8'($urandom),
                          24'($urandom_range(0, 64)));
      endcase
      idle_on = (p % 3 != 1);
      // Stall the result side long enough to back up the input
      if (p == 2) rx_hold = 1'b1;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) random_frame();
      settle();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
